[rtl/core/hkta_pkg.sv]
// Shared constants and the usage-code to ASCII table for the HID keyboard decoder.
// No dependencies; used by hkta_front, hkta_back and the top level.
`default_nettype none

package hkta_pkg;

  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned MODS_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CODE_W-1:0] CODE_LOW   = 8'd4;
  localparam logic [CODE_W-1:0] CODE_HIGH  = 8'd56;
  localparam logic [MODS_W-1:0] SHIFT_MASK = 8'h22;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_DELAY  = 8'd1;

  localparam logic [CFG_DAT_W-1:0] FIRST_DELAY_RST = 8'd20;
  localparam logic [CFG_DAT_W-1:0] NEXT_DELAY_RST  = 8'd1;

  function automatic logic code_mapped(input logic [CODE_W-1:0] code);
    return (code >= CODE_LOW) && (code <= CODE_HIGH);
  endfunction

  // Character for a usage code; only meaningful when code_mapped() is true.
  function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code,
                                                  input logic shift);
    logic [CHAR_W-1:0] off;
    logic [CHAR_W-1:0] ch;
    off = code[CHAR_W-1:0] - 7'd4;
    ch  = 7'h00;
    if (code <= 8'd29) begin
      ch = (shift ? 7'h41 : 7'h61) + off;
    end else begin
      case (code)
        8'd30:   ch = shift ? 7'h21 : 7'h31;
        8'd31:   ch = shift ? 7'h40 : 7'h32;
        8'd32:   ch = shift ? 7'h23 : 7'h33;
        8'd33:   ch = shift ? 7'h24 : 7'h34;
        8'd34:   ch = shift ? 7'h25 : 7'h35;
        8'd35:   ch = shift ? 7'h5E : 7'h36;
        8'd36:   ch = shift ? 7'h26 : 7'h37;
        8'd37:   ch = shift ? 7'h2A : 7'h38;
        8'd38:   ch = shift ? 7'h28 : 7'h39;
        8'd39:   ch = shift ? 7'h29 : 7'h30;
        8'd40:   ch = 7'h0A;
        8'd41:   ch = 7'h1B;
        8'd42:   ch = 7'h08;
        8'd43:   ch = 7'h09;
        8'd44:   ch = 7'h20;
        8'd45:   ch = shift ? 7'h5F : 7'h2D;
        8'd46:   ch = shift ? 7'h2B : 7'h3D;
        8'd47:   ch = shift ? 7'h7B : 7'h5B;
        8'd48:   ch = shift ? 7'h7D : 7'h5D;
        8'd49:   ch = shift ? 7'h7C : 7'h5C;
        8'd50:   ch = 7'h2E;
        8'd51:   ch = shift ? 7'h3A : 7'h3B;
        8'd52:   ch = shift ? 7'h22 : 7'h27;
        8'd53:   ch = shift ? 7'h7E : 7'h60;
        8'd54:   ch = shift ? 7'h3C : 7'h2C;
        8'd55:   ch = shift ? 7'h3E : 7'h2E;
        8'd56:   ch = shift ? 7'h3F : 7'h2F;
        default: ch = 7'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hid_keyboard_report_to_ascii_top.sv]
// Top level of the HID boot keyboard report to ASCII decoder.
// Depends on hkta_pkg, hkta_front, hkta_fifo and hkta_back.
`default_nettype none

// One keyboard report is taken per request on the s_ side; each newly pressed key
// with a code from 4 to 56 becomes one ASCII character on the m_ side, in slot order,
// with tlast on the final character of that report, and a key held unchanged across
// reports repeats on the countdown set by the two delay registers. The classifier
// takes a report every cycle while its two-entry queue has room; the serializer sends
// one character per cycle while m_tready is high, and a report's first character passes
// through the queue, the serializer's pending set and its output register.
// Reports that produce nothing never enter the queue. Register 0 is the first-repeat
// delay (reset 20), register 1 the next-repeat delay (reset 1); write them while idle.
module hid_keyboard_report_to_ascii_top #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // modifiers, key_slot0, key_slot1, ... (8 bits each)
  input  wire logic [8*(KEY_SLOTS+1)-1:0]         s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // ascii_char, then one zero pad bit
  output logic      [7:0]                         m_tdata,
  output logic                                    m_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [hkta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hkta_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int unsigned JOB_W = (KEY_SLOTS + 1) * (hkta_pkg::CHAR_W + 1);

  logic [hkta_pkg::MODS_W-1:0]                  mods;
  logic [KEY_SLOTS-1:0][hkta_pkg::CODE_W-1:0]   keys;
  logic                                         push;
  logic [KEY_SLOTS:0]                           push_mask;
  logic [KEY_SLOTS:0][hkta_pkg::CHAR_W-1:0]     push_chars;
  logic                                         q_full;
  logic                                         q_avail;
  logic                                         q_pop;
  logic [JOB_W-1:0]                             q_data;
  logic [KEY_SLOTS:0]                           q_mask;
  logic [KEY_SLOTS:0][hkta_pkg::CHAR_W-1:0]     q_chars;
  logic [hkta_pkg::CHAR_W-1:0]                  out_char;

  assign cfg_ready = 1'b1;
  assign mods      = s_tdata[7:0];

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
    assign keys[i] = s_tdata[8*(i+1) +: 8];
  end

  hkta_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mods       (mods),
    .keys       (keys),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_mask  (push_mask),
    .push_chars (push_chars)
  );

  hkta_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_chars, push_mask}),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_data)
  );

  assign q_mask  = q_data[KEY_SLOTS:0];
  assign q_chars = q_data[JOB_W-1:KEY_SLOTS+1];

  hkta_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_mask    (q_mask),
    .q_chars   (q_chars),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

[rtl/core/hkta_fifo.sv]
// Small synchronous queue between the report classifier and the character serializer.
// No dependencies.
`default_nettype none

module hkta_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  avail,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign avail    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign pop_data = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/hkta_front.sv]
// Report classifier: finds new presses and the held-key repeat, keeps the previous
// report and the repeat countdown. Depends on hkta_pkg.
`default_nettype none

module hkta_front #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic [hkta_pkg::MODS_W-1:0]                  mods,
  input  wire logic [KEY_SLOTS-1:0][hkta_pkg::CODE_W-1:0]   keys,
  input  wire logic                                         cfg_valid,
  input  wire logic [hkta_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  wire logic [hkta_pkg::CFG_DAT_W-1:0]               cfg_data,
  input  wire logic                                         q_full,
  output logic                                              push,
  output logic      [KEY_SLOTS:0]                           push_mask,
  output logic      [KEY_SLOTS:0][hkta_pkg::CHAR_W-1:0]     push_chars
);

  logic [KEY_SLOTS-1:0][hkta_pkg::CODE_W-1:0] prev_keys;
  logic [7:0]                                 countdown;
  logic [7:0]                                 countdown_next;
  logic [hkta_pkg::CFG_DAT_W-1:0]             first_delay;
  logic [hkta_pkg::CFG_DAT_W-1:0]             next_delay;

  logic                          accept;
  logic                          shift;
  logic                          unchanged;
  logic                          any_key;
  logic                          hold;
  logic                          do_repeat;
  logic [hkta_pkg::CODE_W-1:0]   held;
  logic [KEY_SLOTS-1:0]          seen;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign shift    = (mods & hkta_pkg::SHIFT_MASK) != '0;

  always_comb begin
    unchanged = 1'b1;
    any_key   = 1'b0;
    held      = '0;
    seen      = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (keys[i] != prev_keys[i]) begin
        unchanged = 1'b0;
      end
      if (keys[i] != '0) begin
        any_key = 1'b1;
        held    = keys[i];
      end
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (keys[i] == prev_keys[j]) begin
          seen[i] = 1'b1;
        end
      end
    end
  end

  assign hold      = unchanged && any_key;
  assign do_repeat = hold && (countdown == '0);

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      push_mask[i]  = (keys[i] != '0) && !seen[i] && hkta_pkg::code_mapped(keys[i]);
      push_chars[i] = hkta_pkg::code_char(keys[i], shift);
    end
    // top entry carries the typematic repeat, which is never issued alongside new presses
    push_mask[KEY_SLOTS]  = do_repeat && hkta_pkg::code_mapped(held);
    push_chars[KEY_SLOTS] = hkta_pkg::code_char(held, shift);
  end

  assign push = accept && (push_mask != '0);

  always_comb begin
    if (!hold) begin
      countdown_next = first_delay;
    end else if (do_repeat) begin
      countdown_next = next_delay;
    end else begin
      countdown_next = countdown - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys   <= '0;
      countdown   <= '0;
      first_delay <= hkta_pkg::FIRST_DELAY_RST;
      next_delay  <= hkta_pkg::NEXT_DELAY_RST;
    end else begin
      if (accept) begin
        prev_keys <= keys;
        countdown <= countdown_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          hkta_pkg::REG_FIRST_DELAY: first_delay <= cfg_data;
          hkta_pkg::REG_NEXT_DELAY:  next_delay  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_reload_first: assert property (@(posedge clk) disable iff (rst)
    accept && !hold |=> countdown == $past(first_delay))
    else $error("countdown not reloaded with first delay");

  a_reload_next: assert property (@(posedge clk) disable iff (rst)
    accept && do_repeat |=> countdown == $past(next_delay))
    else $error("countdown not reloaded after repeat");

  a_repeat_alone: assert property (@(posedge clk) disable iff (rst)
    push && push_mask[KEY_SLOTS] |-> push_mask[KEY_SLOTS-1:0] == '0)
    else $error("repeat issued alongside new presses");

endmodule

`default_nettype wire

[rtl/core/hkta_back.sv]
// Character serializer: takes one queued report at a time and sends its characters
// lowest slot first, registered, one per cycle unless stalled. Depends on hkta_pkg.
`default_nettype none

module hkta_back #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     q_avail,
  input  wire logic [KEY_SLOTS:0]                       q_mask,
  input  wire logic [KEY_SLOTS:0][hkta_pkg::CHAR_W-1:0] q_chars,
  output logic                                          q_pop,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic      [hkta_pkg::CHAR_W-1:0]              out_char,
  output logic                                          out_last
);

  logic [KEY_SLOTS:0]                       pend;
  logic [KEY_SLOTS:0][hkta_pkg::CHAR_W-1:0] chars;
  logic [KEY_SLOTS:0]                       sel;
  logic [KEY_SLOTS:0]                       rem;
  logic [hkta_pkg::CHAR_W-1:0]              ch;
  logic                                     adv;

  // lowest pending entry
  assign sel = pend & (~pend + 1'b1);
  assign rem = pend & ~sel;

  always_comb begin
    ch = '0;
    for (int i = 0; i <= KEY_SLOTS; i++) begin
      ch = ch | (chars[i] & {hkta_pkg::CHAR_W{sel[i]}});
    end
  end

  assign adv   = (pend != '0) && (!out_valid || out_ready);
  assign q_pop = q_avail && ((pend == '0) || (adv && (rem == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pend <= q_mask;
      end else if (adv) begin
        pend <= rem;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      chars <= q_chars;
    end
    if (adv) begin
      out_char <= ch;
      out_last <= (rem == '0);
    end
  end

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> pend != '0)
    else $error("non-final character with nothing left");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && (pend != '0) |=> $stable(pend))
    else $error("pending set moved while output stalled");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> pend != '0)
    else $error("empty request taken from queue");

endmodule

`default_nettype wire
